@@ rtl/block_mean_sd_rms_top_macros.svh @@
// Assertion macros for the block statistics unit.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef BLOCK_MEAN_SD_RMS_TOP_MACROS_SVH
`define BLOCK_MEAN_SD_RMS_TOP_MACROS_SVH

`define BMSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define BMSR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ rtl/bmsr_pkg.sv @@
// Shared widths, job and result types for the block statistics unit.
// No dependencies.
package bmsr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = 17;
  localparam int SUM_W       = 33;
  localparam int SQ_W        = 47;
  localparam int MAG_W       = 32;
  localparam int OUT_W       = 24;
  localparam int PROD_W      = 64;
  localparam int NN_W        = 33;
  localparam int DVD_W       = 80;
  localparam int DVS_W       = 33;
  localparam int QUO_W       = 48;
  localparam int DIV_CNT_W   = 7;
  localparam int SQRT_ITER   = 24;
  localparam int SQRT_CNT_W  = 5;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
  } job_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] sd;
    logic [OUT_W-1:0] rms;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } res_t;

endpackage

@@ rtl/bmsr_acc.sv @@
// Front end: accumulates count, sum and sum of squares per sample.
// Depends on bmsr_pkg; hands finished blocks to the job queue.
module bmsr_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic                                full_i,
  input  logic signed [bmsr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  output logic                                job_push_o,
  output bmsr_pkg::job_t                      job_o
);
  import bmsr_pkg::*;

  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sumsq_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    ovf_q;
  logic                    accept;
  logic                    room;
  logic signed [31:0]      sq;
  job_t                    nxt;

  assign accept = push_i & ~full_i;
  assign room   = cnt_q != CNT_W'(MAX_SAMPLES);
  assign sq     = sample_i * sample_i;

  always_comb begin
    nxt.sum   = sum_q;
    nxt.sumsq = sumsq_q;
    nxt.cnt   = cnt_q;
    nxt.ovf   = ovf_q | ~room;
    if (room) begin
      nxt.sum   = sum_q + {{(SUM_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
      nxt.sumsq = sumsq_q + {{(SQ_W-32){1'b0}}, sq};
      nxt.cnt   = cnt_q + CNT_W'(1);
    end
  end

  assign job_o      = nxt;
  assign job_push_o = accept & last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sumsq_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        sum_q   <= '0;
        sumsq_q <= '0;
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= nxt.sum;
        sumsq_q <= nxt.sumsq;
        cnt_q   <= nxt.cnt;
        ovf_q   <= nxt.ovf;
      end
    end
  end

endmodule

@@ rtl/bmsr_q.sv @@
// Two-entry job queue between the accumulator and the math back end.
// Depends on bmsr_pkg.
module bmsr_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bmsr_pkg::job_t din_i,
  output logic           full_o,
  input  logic           pop_i,
  output bmsr_pkg::job_t dout_o,
  output logic           empty_o
);
  import bmsr_pkg::*;

  job_t       mem_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= din_i;
  end

endmodule

@@ rtl/bmsr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on bmsr_pkg; shared by the mean, rms and deviation steps.
module bmsr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bmsr_pkg::DVD_W-1:0] dvd_i,
  input  logic [bmsr_pkg::DVS_W-1:0] dvs_i,
  output logic                       done_o,
  output logic [bmsr_pkg::QUO_W-1:0] quo_o,
  output logic                       rem_nz_o
);
  import bmsr_pkg::*;

  logic [DVD_W-1:0]     dvd_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DVS_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  assign trial    = {rem_q, dvd_q[DVD_W-1]};
  assign ge       = trial >= {1'b0, dvs_q};
  assign diff     = trial - {1'b0, dvs_q};
  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = rem_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dvd_i;
        dvs_q  <= dvs_i;
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= DIV_CNT_W'(DVD_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
        rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], ge};
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/bmsr_sqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on bmsr_pkg.
module bmsr_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bmsr_pkg::QUO_W-1:0] val_i,
  output logic                       done_o,
  output logic [bmsr_pkg::OUT_W-1:0] root_o
);
  import bmsr_pkg::*;

  logic [QUO_W-1:0]      v_q;
  logic [QUO_W-1:0]      res_q;
  logic [QUO_W-1:0]      bit_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [QUO_W-1:0]      trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        v_q    <= val_i;
        res_q  <= '0;
        bit_q  <= QUO_W'(1) << (QUO_W - 2);
        cnt_q  <= SQRT_CNT_W'(SQRT_ITER - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q - SQRT_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/bmsr_back.sv @@
// Back end: products, divides and roots for one block, then the result register.
// Depends on bmsr_pkg, bmsr_div and bmsr_sqrt.
module bmsr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  bmsr_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           res_valid_o,
  output bmsr_pkg::res_t res_o
);
  import bmsr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_VNUM, ST_DMEAN, ST_DRMS, ST_DSD,
    ST_SRMS, ST_SSD, ST_DONE
  } state_e;

  state_e            st_q;
  logic              launched_q;
  job_t              job_q;
  logic              sneg_q;
  logic [MAG_W-1:0]  smag_q;
  logic [PROD_W-1:0] nsq_q;
  logic [PROD_W-1:0] s2_q;
  logic [NN_W-1:0]   nn_q;
  logic [OUT_W-1:0]  mean_q;
  logic [QUO_W-1:0]  rmsq_q;
  logic [QUO_W-1:0]  sdq_q;
  logic [OUT_W-1:0]  rms_q;
  logic [OUT_W-1:0]  sd_q;
  logic              res_valid_q;
  res_t              res_q;

  logic [SUM_W-1:0]  neg_sum;
  logic [40:0]       p_lo;
  logic [39:0]       p_hi;
  logic [33:0]       p_nn;
  logic [PROD_W-1:0] p_s2;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;
  logic              div_rem_nz;
  logic              sq_start;
  logic [QUO_W-1:0]  sq_val;
  logic              sq_done;
  logic [OUT_W-1:0]  sq_root;
  logic [OUT_W-1:0]  mean_mag;
  logic              res_load;

  assign neg_sum  = -job_i.sum;
  assign p_lo     = job_q.cnt * job_q.sumsq[23:0];
  assign p_hi     = job_q.cnt * job_q.sumsq[SQ_W-1:24];
  assign p_nn     = job_q.cnt * job_q.cnt;
  assign p_s2     = smag_q * smag_q;
  assign mean_mag = div_quo[OUT_W-1:0] + OUT_W'(div_rem_nz);
  assign res_load = (st_q == ST_DONE) & (~res_valid_q | pop_i);

  assign job_pop_o   = (st_q == ST_IDLE) & job_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign div_start = ~launched_q &
                     ((st_q == ST_DMEAN) || (st_q == ST_DRMS) || (st_q == ST_DSD));
  assign sq_start  = ~launched_q & ((st_q == ST_SRMS) || (st_q == ST_SSD));
  assign sq_val    = (st_q == ST_SRMS) ? rmsq_q : sdq_q;

  always_comb begin
    unique case (st_q)
      ST_DMEAN: begin
        div_dvd = {{(DVD_W-MAG_W-8){1'b0}}, smag_q, 8'b0};
        div_dvs = {{(DVS_W-CNT_W){1'b0}}, job_q.cnt};
      end
      ST_DRMS: begin
        div_dvd = {{(DVD_W-SQ_W-16){1'b0}}, job_q.sumsq, 16'b0};
        div_dvs = {{(DVS_W-CNT_W){1'b0}}, job_q.cnt};
      end
      default: begin
        div_dvd = {nsq_q, 16'b0};
        div_dvs = nn_q;
      end
    endcase
  end

  bmsr_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .dvd_i    (div_dvd),
    .dvs_i    (div_dvs),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  bmsr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      launched_q  <= 1'b0;
      job_q       <= '0;
      sneg_q      <= 1'b0;
      smag_q      <= '0;
      nsq_q       <= '0;
      s2_q        <= '0;
      nn_q        <= '0;
      mean_q      <= '0;
      rmsq_q      <= '0;
      sdq_q       <= '0;
      rms_q       <= '0;
      sd_q        <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_load) res_valid_q <= 1'b1;
      else if (pop_i) res_valid_q <= 1'b0;
      if (div_start || sq_start) launched_q <= 1'b1;
      unique case (st_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            sneg_q <= job_i.sum[SUM_W-1];
            smag_q <= job_i.sum[SUM_W-1] ? neg_sum[MAG_W-1:0] : job_i.sum[MAG_W-1:0];
            st_q   <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          nsq_q <= {{(PROD_W-41){1'b0}}, p_lo};
          nn_q  <= p_nn[NN_W-1:0];
          st_q  <= ST_MUL1;
        end
        ST_MUL1: begin
          nsq_q <= nsq_q + {p_hi, 24'b0};
          s2_q  <= p_s2;
          st_q  <= ST_VNUM;
        end
        ST_VNUM: begin
          nsq_q <= (nsq_q >= s2_q) ? (nsq_q - s2_q) : '0;
          st_q  <= ST_DMEAN;
        end
        ST_DMEAN: begin
          if (div_done) begin
            mean_q     <= sneg_q ? (OUT_W'(0) - mean_mag) : div_quo[OUT_W-1:0];
            launched_q <= 1'b0;
            st_q       <= ST_DRMS;
          end
        end
        ST_DRMS: begin
          if (div_done) begin
            rmsq_q     <= div_quo;
            launched_q <= 1'b0;
            st_q       <= ST_DSD;
          end
        end
        ST_DSD: begin
          if (div_done) begin
            sdq_q      <= div_quo;
            launched_q <= 1'b0;
            st_q       <= ST_SRMS;
          end
        end
        ST_SRMS: begin
          if (sq_done) begin
            rms_q      <= sq_root;
            launched_q <= 1'b0;
            st_q       <= ST_SSD;
          end
        end
        ST_SSD: begin
          if (sq_done) begin
            sd_q       <= sq_root;
            launched_q <= 1'b0;
            st_q       <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            res_q.mean <= mean_q;
            res_q.sd   <= sd_q;
            res_q.rms  <= rms_q;
            res_q.cnt  <= job_q.cnt;
            res_q.ovf  <= job_q.ovf;
            st_q       <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/block_mean_sd_rms_top.sv @@
// Block mean, standard deviation and rms over a stream of signed 16-bit samples.
// A sample is taken every cycle while full is low; the accumulator adds it to its sums.
// The sample marked last closes the block and queues it for the math back end, which
// runs the product steps ST_MUL0, ST_MUL1 and ST_VNUM, three passes of the shared
// 80-step bit-serial divider and two passes of the 24-step square root. Up to
// two closed blocks wait in the job queue; full rises only while both are waiting.
// Results carry 8 fraction bits. Samples past 65536 in one block are dropped and flagged.
// Depends on bmsr_pkg, bmsr_acc, bmsr_q, bmsr_back and the assertion macro header.
module block_mean_sd_rms_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [bmsr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_sample_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [bmsr_pkg::OUT_W-1:0]   block_mean_o,
  output logic [bmsr_pkg::OUT_W-1:0]          block_sd_o,
  output logic [bmsr_pkg::OUT_W-1:0]          block_rms_o,
  output logic [bmsr_pkg::CNT_W-1:0]          sample_count_o,
  output logic                                overflowed_o
);
  import bmsr_pkg::*;
  `include "block_mean_sd_rms_top_macros.svh"

  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_empty;
  job_t job_out;
  logic job_pop;
  logic res_valid;
  res_t res;

  assign full = job_full;

  bmsr_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (job_full),
    .sample_i   (sample_i),
    .last_i     (last_sample_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  bmsr_q u_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .din_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .dout_o  (job_out),
    .empty_o (job_empty)
  );

  bmsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (~job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty          = ~res_valid;
  assign block_mean_o   = res.mean;
  assign block_sd_o     = res.sd;
  assign block_rms_o    = res.rms;
  assign sample_count_o = res.cnt;
  assign overflowed_o   = res.ovf;

  `BMSR_ASSERT_NEVER(a_job_lost, job_push && job_full, "block closed while job queue full")
  `BMSR_ASSERT_IMPL(a_cnt_nz, !empty, sample_count_o != '0, "result with zero samples")
  `BMSR_ASSERT_IMPL(a_ovf_cnt, !empty && overflowed_o,
                    sample_count_o == CNT_W'(MAX_SAMPLES), "overflow below max count")
  `BMSR_ASSERT_IMPL(a_sd_le_rms, !empty, block_sd_o <= block_rms_o, "deviation above rms")

endmodule

@@ sim/testbench.sv @@
// Testbench for block_mean_sd_rms_top: streams signed sample blocks, predicts mean, sd and rms.
// Checks every result against an in-order queue of predictions under varied handshake idling.
// Depends on bmsr_pkg and the RTL of block_mean_sd_rms_top.
module testbench;
  import bmsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       last_sample_i = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [OUT_W-1:0]    block_mean_o;
  logic [OUT_W-1:0]           block_sd_o;
  logic [OUT_W-1:0]           block_rms_o;
  logic [CNT_W-1:0]           sample_count_o;
  logic                       overflowed_o;

  block_mean_sd_rms_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .sample_i(sample_i), .last_sample_i(last_sample_i),
    .empty(empty), .pop(pop),
    .block_mean_o(block_mean_o), .block_sd_o(block_sd_o), .block_rms_o(block_rms_o),
    .sample_count_o(sample_count_o), .overflowed_o(overflowed_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  longint          acc_sum;
  longint unsigned acc_sumsq;
  int unsigned     acc_count;
  bit              acc_ovf;
  res_t            pending_stats[$];
  int              send_idle_pct;
  int              pop_stall_pct;
  int              mismatches;
  int              samples_sent;
  int              blocks_checked;
  int              idle_cycles;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s, input bit last);
    longint          sv;
    longint unsigned smag, n, nn, vnum, q, r, mean_u, sd_u, rms_u;
    res_t            stats;
    sv = s;
    if (acc_count >= MAX_SAMPLES) begin
      acc_ovf = 1'b1;
    end else begin
      acc_sum += sv;
      acc_sumsq += longint'(sv * sv);
      acc_count++;
    end
    if (!last) return;
    n = acc_count;
    smag = (acc_sum < 0) ? longint'(-acc_sum) : acc_sum;
    if (acc_sum < 0) mean_u = 64'd0 - ((smag * 256 + n - 1) / n);
    else mean_u = (smag * 256) / n;
    nn = n * n;
    vnum = n * acc_sumsq;
    if (vnum >= smag * smag) vnum -= smag * smag;
    else vnum = 0;
    q = vnum / nn;
    r = vnum % nn;
    sd_u = floor_sqrt((q << 16) + ((r << 16) / nn));
    rms_u = floor_sqrt((acc_sumsq << 16) / n);
    stats.mean = mean_u[OUT_W-1:0];
    stats.sd   = sd_u[OUT_W-1:0];
    stats.rms  = rms_u[OUT_W-1:0];
    stats.cnt  = n[CNT_W-1:0];
    stats.ovf  = acc_ovf;
    pending_stats.push_back(stats);
    acc_sum = 0;
    acc_sumsq = 0;
    acc_count = 0;
    acc_ovf = 1'b0;
  endtask

  // call at a falling edge; returns at the falling edge after the request is taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    sample_i <= s;
    last_sample_i <= last;
    do @(posedge clk_i); while (full);
    accumulate_sample(s, last);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(3))
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'($urandom_range(255) - 128);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return SAMPLE_W'($urandom_range(32767) -
                                (($urandom_range(1) != 0) ? 32768 : 0));
    endcase
  endfunction

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_stats.size() == 0) begin
        $error("unexpected result: mean %0d count %0d", block_mean_o, sample_count_o);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        blocks_checked++;
        if (block_mean_o !== want.mean) begin
          $error("block_mean: expected %0d actual %0d", $signed(want.mean), block_mean_o);
          mismatches++;
        end
        if (block_sd_o !== want.sd) begin
          $error("block_sd: expected %0d actual %0d", want.sd, block_sd_o);
          mismatches++;
        end
        if (block_rms_o !== want.rms) begin
          $error("block_rms: expected %0d actual %0d", want.rms, block_rms_o);
          mismatches++;
        end
        if (sample_count_o !== want.cnt) begin
          $error("sample_count: expected %0d actual %0d", want.cnt, sample_count_o);
          mismatches++;
        end
        if (overflowed_o !== want.ovf) begin
          $error("overflowed: expected %0d actual %0d", want.ovf, overflowed_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic test_extremes();
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(-16'sd4, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_blocks(input int items, input int idle_pct, input int stall_pct);
    int sent, len;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(400, 1) : $urandom_range(20, 1);
      for (int i = 0; i < len; i++) send_sample(random_sample(), i == len - 1);
      sent += len;
      if ($urandom_range(7) == 0) begin
        send_idle_pct = 0;
        repeat ($urandom_range(30, 5)) send_sample(random_sample(), 1'b0);
        send_sample(random_sample(), 1'b1);
        send_idle_pct = idle_pct;
      end
    end
    wait_drain();
  endtask

  initial begin
    acc_sum = 0;
    acc_sumsq = 0;
    acc_count = 0;
    acc_ovf = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    blocks_checked = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_random_blocks(440, 0, 0);
    test_random_blocks(440, 76, 0);
    test_random_blocks(440, 0, 76);
    test_random_blocks(440, 37, 37);
    pop_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_stats.size() != 0) begin
      $error("%0d expected results never arrived", pending_stats.size());
      mismatches++;
    end
    $display("covered %0d samples in %0d checked blocks, incl. full-scale extremes",
             samples_sent, blocks_checked);
    $display("idling phases: none, sender, receiver, both; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
